// ===== design/siu_pkg.sv =====
package siu_pkg;

  localparam int MaxIntervals = 16;
  localparam int ValueBits    = 16;
  localparam int IdxW         = $clog2(MaxIntervals);
  localparam int CntW         = $clog2(MaxIntervals + 1);
  localparam int EntryW       = 2 * ValueBits;
  // two banks of the list, ping-pong
  localparam int RamDepth     = 2 * (1 << IdxW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_MERGE,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan_en;
    logic merge;
    logic emit_en;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic scan_last;
    logic emit_last;
  } sts_t;

  typedef struct packed {
    logic [ValueBits-1:0] start_v;
    logic [ValueBits-1:0] end_v;
    logic [IdxW-1:0]      idx;
    logic [CntW-1:0]      cnt;
    logic                 valid;
    logic                 ovf;
    logic                 last;
  } res_t;

endpackage

// ===== design/sorted_interval_union_top.sv =====
// channel | handshake             | beat payload
// --------+-----------------------+---------------------------------------------
// in      | in_valid_i/in_ready_o | mode_i, new_start_i, new_end_i
// out     | out_valid_o/out_ready_i | out_start_o, out_end_o, entry_index_o,
//         |                       | entry_count_o, entry_valid_o, overflow_o, last_o
//
// Insert with n stored intervals: accept, n scan reads, drain, merge write
// (scan and drain skipped when n is 0), then one result beat per cycle while the
// output stage has room, one per interval stored afterwards (at most n+1, n when
// the insert overflows). Clear: accept, then one result beat. Scan and emit share
// the single RAM read port, one entry per cycle; the list lives in two RAM banks.
// Reset empties the list; no clearing pass. Output stalls pause the emit reads
// once the two-slot output stage is full; next item is accepted once all reads issued.
module sorted_interval_union_top import siu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  input  logic [ValueBits-1:0] new_start_i,
  input  logic [ValueBits-1:0] new_end_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ValueBits-1:0] out_start_o,
  output logic [ValueBits-1:0] out_end_o,
  output logic [IdxW-1:0]      entry_index_o,
  output logic [CntW-1:0]      entry_count_o,
  output logic                 entry_valid_o,
  output logic                 overflow_o,
  output logic                 last_o
);

  cmd_t cmd;
  sts_t sts;
  res_t res;

  siu_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .mode_i    (mode_i),
    .sts_i     (sts),
    .in_ready_o(in_ready_o),
    .cmd_o     (cmd)
  );

  siu_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .new_start_i(new_start_i),
    .new_end_i  (new_end_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .res_o      (res)
  );

  assign out_start_o   = res.start_v;
  assign out_end_o     = res.end_v;
  assign entry_index_o = res.idx;
  assign entry_count_o = res.cnt;
  assign entry_valid_o = res.valid;
  assign overflow_o    = res.ovf;
  assign last_o        = res.last;

endmodule

// ===== design/siu_ram.sv =====
module siu_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/siu_ctrl.sv =====
module siu_ctrl import siu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic mode_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (mode_i) begin
            state_d = S_EMIT;
          end else if (sts_i.cnt_zero) begin
            state_d = S_MERGE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_MERGE;
      S_MERGE: state_d = S_EMIT;
      S_EMIT: begin
        if (sts_i.emit_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load    = in_valid_i & ~mode_i;
        cmd_o.clear   = in_valid_i & mode_i;
      end
      S_SCAN:  cmd_o.scan_en = 1'b1;
      S_DRAIN: ;
      S_MERGE: cmd_o.merge = 1'b1;
      S_EMIT:  cmd_o.emit_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/siu_datapath.sv =====
module siu_datapath import siu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [ValueBits-1:0] new_start_i,
  input  logic [ValueBits-1:0] new_end_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output res_t                 res_o
);

  localparam int CntXW = CntW + 1;
  localparam int RamAw = $clog2(RamDepth);

  // list state
  logic                 bank_q, bank_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  // insert working state
  logic [ValueBits-1:0] ns_q, ns_d, ne_q, ne_d;
  logic [CntW-1:0]      wptr_q, wptr_d, nb_q, nb_d, rd_idx_q, rd_idx_d;
  logic                 scan_pend_q;
  // emit pipeline
  logic                 pend_q, pend_empty_q;
  logic [IdxW-1:0]      pend_idx_q;
  res_t                 out_q, out_d, skid_q, skid_d;
  logic                 out_v_q, out_v_d, skid_v_q, skid_v_d;

  logic                 we, re;
  logic [RamAw-1:0]     waddr, raddr;
  logic [EntryW-1:0]    wdata, rdata;

  logic [ValueBits-1:0] lo_in, hi_in, a_val, b_val;
  logic [CntXW-1:0]     wptr_inc;
  logic [CntW-1:0]      rd_inc, total;
  logic                 room_after, fits, is_before, is_after;
  logic                 pop, take, credit_ok, emit_issue, scan_last, emit_last;
  logic [1:0]           occ_left;
  res_t                 arr;

  siu_ram #(
    .Width(EntryW),
    .Depth(RamDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign lo_in = (new_start_i > new_end_i) ? new_end_i : new_start_i;
  assign hi_in = (new_start_i > new_end_i) ? new_start_i : new_end_i;
  assign a_val = rdata[EntryW-1:ValueBits];
  assign b_val = rdata[ValueBits-1:0];

  // stored list is strictly disjoint and sorted, so one pass splits it into
  // before / overlapping / after runs
  assign is_before  = b_val < ns_q;
  assign is_after   = a_val > ne_q;
  assign wptr_inc   = {1'b0, wptr_q} + 1'b1;
  assign room_after = wptr_inc < CntXW'(MaxIntervals);
  assign fits       = wptr_inc <= CntXW'(MaxIntervals);

  assign rd_inc = rd_idx_q + 1'b1;
  assign total  = (cnt_q == '0) ? CntW'(1) : cnt_q;

  // two result slots (out + skid); a read in flight holds a slot
  assign pop        = out_v_q & out_ready_i;
  assign take       = ~out_v_q | pop;
  assign occ_left   = {1'b0, out_v_q} + {1'b0, skid_v_q} + {1'b0, pend_q} - {1'b0, pop};
  assign credit_ok  = occ_left < 2'd2;
  assign emit_issue = cmd_i.emit_en & credit_ok;
  assign scan_last  = rd_inc == cnt_q;
  assign emit_last  = emit_issue & (rd_inc == total);

  assign sts_o.cnt_zero  = cnt_q == '0;
  assign sts_o.scan_last = scan_last;
  assign sts_o.emit_last = emit_last;

  assign re    = cmd_i.scan_en | (emit_issue & (cnt_q != '0));
  assign raddr = {bank_q, rd_idx_q[IdxW-1:0]};

  always_comb begin
    we    = 1'b0;
    waddr = {~bank_q, wptr_q[IdxW-1:0]};
    wdata = rdata;
    if (scan_pend_q) begin
      if (is_before) begin
        we = 1'b1;
      end else if (is_after && room_after) begin
        we    = 1'b1;
        waddr = {~bank_q, wptr_inc[IdxW-1:0]};
      end
    end else if (cmd_i.merge && fits) begin
      we    = 1'b1;
      waddr = {~bank_q, nb_q[IdxW-1:0]};
      wdata = {ns_q, ne_q};
    end
  end

  always_comb begin
    bank_d   = bank_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    ns_d     = ns_q;
    ne_d     = ne_q;
    wptr_d   = wptr_q;
    nb_d     = nb_q;
    rd_idx_d = rd_idx_q;
    if (cmd_i.load) begin
      ns_d     = lo_in;
      ne_d     = hi_in;
      wptr_d   = '0;
      nb_d     = '0;
      ovf_d    = 1'b0;
      rd_idx_d = '0;
    end
    if (cmd_i.clear) begin
      cnt_d    = '0;
      ovf_d    = 1'b0;
      rd_idx_d = '0;
    end
    if (cmd_i.scan_en) begin
      rd_idx_d = scan_last ? '0 : rd_inc;
    end
    if (emit_issue) begin
      rd_idx_d = emit_last ? '0 : rd_inc;
    end
    if (scan_pend_q) begin
      if (is_before) begin
        wptr_d = wptr_inc[CntW-1:0];
        nb_d   = nb_q + 1'b1;
      end else if (is_after) begin
        wptr_d = wptr_inc[CntW-1:0];
      end else begin
        if (a_val < ns_q) ns_d = a_val;
        if (b_val > ne_q) ne_d = b_val;
      end
    end
    if (cmd_i.merge) begin
      if (fits) begin
        bank_d = ~bank_q;
        cnt_d  = wptr_inc[CntW-1:0];
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  // result built from the beat that comes back from the RAM
  always_comb begin
    arr     = '0;
    arr.ovf = ovf_q;
    if (pend_empty_q) begin
      arr.last = 1'b1;
    end else begin
      arr.start_v = a_val;
      arr.end_v   = b_val;
      arr.idx     = pend_idx_q;
      arr.cnt     = cnt_q;
      arr.valid   = 1'b1;
      arr.last    = (CntW'(pend_idx_q) + 1'b1) == cnt_q;
    end
  end

  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (take) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_d   = arr;
        skid_v_d = pend_q;
      end else begin
        out_d   = arr;
        out_v_d = pend_q;
      end
    end else if (pend_q) begin
      skid_d   = arr;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q       <= 1'b0;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      wptr_q       <= '0;
      nb_q         <= '0;
      rd_idx_q     <= '0;
      scan_pend_q  <= 1'b0;
      pend_q       <= 1'b0;
      pend_empty_q <= 1'b0;
      pend_idx_q   <= '0;
      out_v_q      <= 1'b0;
      skid_v_q     <= 1'b0;
    end else begin
      bank_q       <= bank_d;
      cnt_q        <= cnt_d;
      ovf_q        <= ovf_d;
      wptr_q       <= wptr_d;
      nb_q         <= nb_d;
      rd_idx_q     <= rd_idx_d;
      scan_pend_q  <= cmd_i.scan_en;
      pend_q       <= emit_issue;
      if (emit_issue) begin
        pend_empty_q <= cnt_q == '0;
        pend_idx_q   <= rd_idx_q[IdxW-1:0];
      end
      out_v_q      <= out_v_d;
      skid_v_q     <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ns_q   <= ns_d;
    ne_q   <= ne_d;
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_v_q;
  assign res_o       = out_q;

endmodule

// ===== design/siu_checker.sv =====
module siu_checker import siu_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 mode_i,
  input logic [ValueBits-1:0] new_start_i,
  input logic [ValueBits-1:0] new_end_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [ValueBits-1:0] out_start_o,
  input logic [ValueBits-1:0] out_end_o,
  input logic [IdxW-1:0]      entry_index_o,
  input logic [CntW-1:0]      entry_count_o,
  input logic                 entry_valid_o,
  input logic                 overflow_o,
  input logic                 last_o
);

  logic [CntW-1:0] idx_next;
  assign idx_next = CntW'(entry_index_o) + 1'b1;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_start_o) &&
      $stable(out_end_o) && $stable(entry_index_o) && $stable(last_o) &&
      $stable(overflow_o))
    else $error("stalled result beat changed");

  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !entry_valid_o |-> last_o && entry_count_o == '0 &&
      entry_index_o == '0 && out_start_o == '0 && out_end_o == '0)
    else $error("empty-list beat malformed");

  a_index_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_valid_o |-> idx_next <= entry_count_o &&
      last_o == (idx_next == entry_count_o) && out_start_o <= out_end_o)
    else $error("entry index, count or last marker inconsistent");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in work");

endmodule

bind sorted_interval_union_top siu_checker u_siu_checker (.*);

// ===== tb/tb_sorted_interval_union_top.sv =====
`timescale 1ns / 1ps

module tb_sorted_interval_union_top;
  import siu_pkg::*;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  localparam int RandomSpans   = 430;
  localparam int WatchdogLimit = 3000;
  localparam int HoldCycles    = 300;
  localparam int DrainCycles   = 40;

  typedef struct packed {
    logic                 mode;
    logic [ValueBits-1:0] s_val;
    logic [ValueBits-1:0] e_val;
  } span_req_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 mode_i = MODE_INSERT;
  logic [ValueBits-1:0] new_start_i = '0;
  logic [ValueBits-1:0] new_end_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [ValueBits-1:0] out_start_o;
  logic [ValueBits-1:0] out_end_o;
  logic [IdxW-1:0]      entry_index_o;
  logic [CntW-1:0]      entry_count_o;
  logic                 entry_valid_o;
  logic                 overflow_o;
  logic                 last_o;

  sorted_interval_union_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .new_start_i  (new_start_i),
    .new_end_i    (new_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_start_o  (out_start_o),
    .out_end_o    (out_end_o),
    .entry_index_o(entry_index_o),
    .entry_count_o(entry_count_o),
    .entry_valid_o(entry_valid_o),
    .overflow_o   (overflow_o),
    .last_o       (last_o)
  );

  span_req_t pending_spans[$];
  res_t      expected_entries[$];

  // shadow copy of the stored list
  logic [ValueBits-1:0] list_lo[MaxIntervals];
  logic [ValueBits-1:0] list_hi[MaxIntervals];
  int                   list_len = 0;

  int        sent_cnt = 0;
  int        taken_cnt = 0;
  int        total_spans = 0;
  int        fail_cnt = 0;
  int        stall_cycles = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  span_req_t head_span;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic push_span(input logic mode, input int s, input int e);
    span_req_t r;
    r.mode  = mode;
    r.s_val = s[ValueBits-1:0];
    r.e_val = e[ValueBits-1:0];
    pending_spans.insert(pending_spans.size(), r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_cnt++;
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  // Fold one accepted beat into the shadow list and queue the list dump it causes.
  task automatic fold_span(input span_req_t req);
    logic [ValueBits-1:0] lo, hi, a, b;
    logic [ValueBits-1:0] nlo[MaxIntervals+1];
    logic [ValueBits-1:0] nhi[MaxIntervals+1];
    int   n;
    logic ovf;
    res_t r;
    ovf = 1'b0;
    if (req.mode == MODE_CLEAR) begin
      list_len = 0;
    end else begin
      lo = req.s_val;
      hi = req.e_val;
      if (lo > hi) begin
        lo = req.e_val;
        hi = req.s_val;
      end
      n = 0;
      for (int i = 0; i < list_len; i++) begin
        if (list_hi[i] < lo) begin
          nlo[n] = list_lo[i];
          nhi[n] = list_hi[i];
          n++;
        end
      end
      // touching counts as overlap: only strict gaps keep an entry apart
      for (int i = 0; i < list_len; i++) begin
        a = list_lo[i];
        b = list_hi[i];
        if (!(b < lo) && !(a > hi)) begin
          if (a < lo) lo = a;
          if (b > hi) hi = b;
        end
      end
      nlo[n] = lo;
      nhi[n] = hi;
      n++;
      for (int i = 0; i < list_len; i++) begin
        if (list_lo[i] > hi) begin
          nlo[n] = list_lo[i];
          nhi[n] = list_hi[i];
          n++;
        end
      end
      if (n > MaxIntervals) begin
        ovf = 1'b1;
      end else begin
        for (int i = 0; i < n; i++) begin
          list_lo[i] = nlo[i];
          list_hi[i] = nhi[i];
        end
        list_len = n;
      end
    end
    if (list_len == 0) begin
      r = '0;
      r.ovf  = ovf;
      r.last = 1'b1;
      expected_entries.insert(expected_entries.size(), r);
    end else begin
      for (int i = 0; i < list_len; i++) begin
        r.start_v = list_lo[i];
        r.end_v   = list_hi[i];
        r.idx     = i[IdxW-1:0];
        r.cnt     = list_len[CntW-1:0];
        r.valid   = 1'b1;
        r.ovf     = ovf;
        r.last    = (i + 1 == list_len);
        expected_entries.insert(expected_entries.size(), r);
      end
    end
  endtask

  // driver: one decision per falling edge, valid held until the beat is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && sent_cnt != taken_cnt)) begin
      if (pending_spans.size() != 0 &&
          ((taken_cnt >= 150 && taken_cnt < 230) || $urandom_range(0, 99) >= 34)) begin
        head_span = pending_spans.pop_front();
        in_valid_i  <= 1'b1;
        mode_i      <= head_span.mode;
        new_start_i <= head_span.s_val;
        new_end_i   <= head_span.e_val;
        sent_cnt++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold-off so the output stage backs up
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (!hold_done && taken_cnt >= 100) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (taken_cnt >= 150 && taken_cnt < 230) ||
                       ($urandom_range(0, 99) >= 34);
      end
    end
  end

  // monitor: sample both channels at the rising edge
  always @(posedge clk_i) begin
    res_t want;
    bit   moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && in_ready_o) begin
        fold_span('{mode_i, new_start_i, new_end_i});
        taken_cnt++;
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (expected_entries.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = expected_entries.pop_front();
          if (out_start_o !== want.start_v)
            report_mismatch("out_start", out_start_o, want.start_v);
          if (out_end_o !== want.end_v)
            report_mismatch("out_end", out_end_o, want.end_v);
          if (entry_index_o !== want.idx)
            report_mismatch("entry_index", entry_index_o, want.idx);
          if (entry_count_o !== want.cnt)
            report_mismatch("entry_count", entry_count_o, want.cnt);
          if (entry_valid_o !== want.valid)
            report_mismatch("entry_valid", entry_valid_o, want.valid);
          if (overflow_o !== want.ovf)
            report_mismatch("overflow", overflow_o, want.ovf);
          if (last_o !== want.last)
            report_mismatch("last", last_o, want.last);
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
        $display("%0t ns: no progress for %0d cycles", $time, WatchdogLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int s, e, w, pick;

    // directed: clear on empty list, fill to capacity, then overflow and merges
    push_span(MODE_CLEAR, 16'hFFFF, 16'h0000);
    for (int i = 0; i < MaxIntervals; i++) begin
      if (i == 0) begin
        s = 0;
        e = 0;
      end else if (i == MaxIntervals - 1) begin
        s = 65535;
        e = 65535;
      end else begin
        s = i * 4096 + 1000;
        e = s + 100;
      end
      if (i % 2 == 1) push_span(MODE_INSERT, e, s);
      else push_span(MODE_INSERT, s, e);
    end
    push_span(MODE_INSERT, 2000, 2010);    // lands in a gap of a full list
    push_span(MODE_INSERT, 5196, 5096);    // equal to a stored entry, reversed
    push_span(MODE_INSERT, 5196, 9192);    // touches two neighbors at their ends
    push_span(MODE_INSERT, 65534, 65535);  // touches the top entry
    push_span(MODE_INSERT, 0, 65535);      // swallows everything
    push_span(MODE_CLEAR, 16'h1234, 16'h8765);
    push_span(MODE_INSERT, 65535, 0);

    for (int k = 0; k < RandomSpans; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        push_span(MODE_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else begin
        s = $urandom_range(0, 65535);
        if (pick < 60) begin
          w = $urandom_range(0, 300);
        end else if (pick < 75) begin
          w = $urandom_range(0, 8000);
        end else if (pick < 80) begin
          w = $urandom_range(0, 65535);
        end else begin
          // grid endpoints so stored ends and new starts coincide often
          s = $urandom_range(0, 31) * 2048;
          w = $urandom_range(0, 3) * 2048;
        end
        e = (s + w > 65535) ? 65535 : s + w;
        if ($urandom_range(0, 3) == 0) push_span(MODE_INSERT, e, s);
        else push_span(MODE_INSERT, s, e);
      end
    end
    total_spans = pending_spans.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (taken_cnt != total_spans || expected_entries.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
